[sv/mqd_pkg.sv]
package mqd_pkg;

    localparam int POS_WIDTH   = 33;
    localparam int TRQ_WIDTH   = 16;
    localparam int HYST_WIDTH  = 16;
    localparam int TOL_WIDTH   = 15;
    localparam int CFG_WIDTH   = 16;
    localparam int INDEX_WIDTH = 2;
    localparam int DELTA_WIDTH = POS_WIDTH + 2;

    // Position span and half span in 1/256 degree units.
    localparam logic signed [DELTA_WIDTH-1:0] POS_SPAN      = 35'sd6039797760;
    localparam logic signed [DELTA_WIDTH-1:0] POS_HALF_SPAN = 35'sd3019898880;

    localparam logic [INDEX_WIDTH-1:0] REG_DIRECTION_HYSTERESIS = 2'd0;
    localparam logic [INDEX_WIDTH-1:0] REG_TORQUE_TOLERANCE     = 2'd1;

    localparam logic [HYST_WIDTH-1:0] HYST_RESET = 16'd256;
    localparam logic [TOL_WIDTH-1:0]  TOL_RESET  = 15'd8;

    localparam logic signed [1:0] SIGN_POS  = 2'sb01;
    localparam logic signed [1:0] SIGN_NEG  = 2'sb11;
    localparam logic signed [1:0] SIGN_ZERO = 2'sb00;

    localparam logic [2:0] QUADRANT_1 = 3'd1;
    localparam logic [2:0] QUADRANT_2 = 3'd2;
    localparam logic [2:0] QUADRANT_3 = 3'd3;
    localparam logic [2:0] QUADRANT_4 = 3'd4;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] reference_position;
        logic signed [1:0]           held_direction;
        logic signed [1:0]           held_torque_sign;
    } mqd_state_t;

    typedef struct packed {
        logic [HYST_WIDTH-1:0] direction_hysteresis;
        logic [TOL_WIDTH-1:0]  torque_tolerance;
    } mqd_cfg_t;

endpackage

[sv/mqd_eval.sv]
module mqd_eval (
    input  logic signed [mqd_pkg::POS_WIDTH-1:0] motor_position,
    input  logic signed [mqd_pkg::TRQ_WIDTH-1:0] torque_command,
    input  mqd_pkg::mqd_state_t                  state_cur,
    input  mqd_pkg::mqd_cfg_t                    cfg,
    output mqd_pkg::mqd_state_t                  state_new,
    output logic signed [1:0]                    motor_direction,
    output logic [2:0]                           quadrant
);
    import mqd_pkg::*;

    logic signed [DELTA_WIDTH-1:0] delta_raw;
    logic signed [DELTA_WIDTH-1:0] delta;
    logic signed [DELTA_WIDTH-1:0] mag;
    logic signed [1:0]             dsign;
    logic signed [TRQ_WIDTH:0]     trq_ext;
    logic [TRQ_WIDTH:0]            trq_mag;
    logic signed [1:0]             tsign;

    always_comb begin
        delta_raw = DELTA_WIDTH'(motor_position) - DELTA_WIDTH'(state_cur.reference_position);
        // The change is wrapped by at most one span to cover position rollover.
        if (delta_raw > POS_HALF_SPAN) begin
            delta = delta_raw - POS_SPAN;
        end else if (delta_raw < -POS_HALF_SPAN) begin
            delta = delta_raw + POS_SPAN;
        end else begin
            delta = delta_raw;
        end
        mag = delta[DELTA_WIDTH-1] ? -delta : delta;

        if (delta[DELTA_WIDTH-1]) begin
            dsign = SIGN_NEG;
        end else if (delta != '0) begin
            dsign = SIGN_POS;
        end else begin
            dsign = SIGN_ZERO;
        end

        state_new = state_cur;
        if (state_cur.held_direction == dsign) begin
            state_new.reference_position = motor_position;
        end else if (mag >= DELTA_WIDTH'(cfg.direction_hysteresis)) begin
            state_new.held_direction     = dsign;
            state_new.reference_position = motor_position;
        end

        trq_ext = (TRQ_WIDTH+1)'(torque_command);
        trq_mag = trq_ext[TRQ_WIDTH] ? unsigned'(-trq_ext) : unsigned'(trq_ext);
        // A magnitude above the tolerance is never zero, so the sign is +1 or -1.
        tsign   = torque_command[TRQ_WIDTH-1] ? SIGN_NEG : SIGN_POS;
        if (trq_mag > (TRQ_WIDTH+1)'(cfg.torque_tolerance)) begin
            state_new.held_torque_sign = tsign;
        end

        if (state_new.held_torque_sign == state_new.held_direction) begin
            quadrant = (state_new.held_torque_sign == SIGN_POS) ? QUADRANT_1 : QUADRANT_3;
        end else begin
            quadrant = (state_new.held_torque_sign == SIGN_POS) ? QUADRANT_2 : QUADRANT_4;
        end
        motor_direction = state_new.held_direction;
    end

endmodule

[sv/motor_quadrant_detector_top.sv]
// Four-quadrant motor operation detector.
// Input channel (s_valid/s_ready): one transaction carries a cumulative motor
// position in 1/256 degree and a torque command in 1/2048 Nm.
// Output channel (m_valid/m_ready): one transaction per input, carrying the
// held motor direction (-1, 0, +1) and the operating quadrant 1 to 4.
// Configuration: cfg_wr_en, cfg_index and cfg_data write the direction
// hysteresis (index 0) and the torque tolerance (index 1);
// other indexes are ignored. Write only while no transaction is in flight.
// Each input transaction is captured in the input register and then passes
// through the evaluation logic into the result register. Throughput: one
// transaction per cycle while the receiver does not stall, set by the single
// evaluation pass that updates the reference, direction and torque sign.
// Reset clears the pipeline, sets the reference and direction to zero, the
// torque sign to +1 and the registers to their defaults.
// When the receiver stalls the result register holds, the input register
// keeps one more transaction, and s_ready drops until m_ready returns.
module motor_quadrant_detector_top (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [mqd_pkg::INDEX_WIDTH-1:0]         cfg_index,
    input  logic [mqd_pkg::CFG_WIDTH-1:0]           cfg_data,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [mqd_pkg::POS_WIDTH-1:0]    s_motor_position,
    input  logic signed [mqd_pkg::TRQ_WIDTH-1:0]    s_torque_command,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [1:0]                       m_motor_direction,
    output logic [2:0]                              m_quadrant
);
    import mqd_pkg::*;

    mqd_cfg_t                    cfg_reg;
    mqd_state_t                  state_reg;
    mqd_state_t                  state_next;
    logic                        in_valid_reg;
    logic signed [POS_WIDTH-1:0] pos_reg;
    logic signed [TRQ_WIDTH-1:0] trq_reg;
    logic                        out_valid_reg;
    logic signed [1:0]           dir_reg;
    logic [2:0]                  quad_reg;
    logic signed [1:0]           dir_next;
    logic [2:0]                  quad_next;
    logic                        advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    mqd_eval u_eval (
        .motor_position  (pos_reg),
        .torque_command  (trq_reg),
        .state_cur       (state_reg),
        .cfg             (cfg_reg),
        .state_new       (state_next),
        .motor_direction (dir_next),
        .quadrant        (quad_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.direction_hysteresis <= HYST_RESET;
            cfg_reg.torque_tolerance     <= TOL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DIRECTION_HYSTERESIS: cfg_reg.direction_hysteresis <= cfg_data;
                REG_TORQUE_TOLERANCE:     cfg_reg.torque_tolerance <= cfg_data[TOL_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg                 <= 1'b0;
            out_valid_reg                <= 1'b0;
            state_reg.reference_position <= '0;
            state_reg.held_direction     <= SIGN_ZERO;
            state_reg.held_torque_sign   <= SIGN_POS;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pos_reg <= s_motor_position;
            trq_reg <= s_torque_command;
        end
        if (advance) begin
            dir_reg  <= dir_next;
            quad_reg <= quad_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_motor_direction = dir_reg;
    assign m_quadrant        = quad_reg;

endmodule

[verif/tb_motor_quadrant_detector_top.sv]
`timescale 1ns / 1ps

module tb_motor_quadrant_detector_top;
    import mqd_pkg::*;

    localparam logic [INDEX_WIDTH-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [INDEX_WIDTH-1:0] REG_SPARE_3 = 2'd3;
    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef struct {
        logic signed [POS_WIDTH-1:0] pos;
        logic signed [TRQ_WIDTH-1:0] trq;
    } motor_input_t;

    typedef struct {
        logic signed [1:0] dir;
        logic [2:0]        quad;
    } operating_point_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic [INDEX_WIDTH-1:0]       cfg_index = '0;
    logic [CFG_WIDTH-1:0]         cfg_data = '0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic signed [POS_WIDTH-1:0]  s_motor_position = '0;
    logic signed [TRQ_WIDTH-1:0]  s_torque_command = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic signed [1:0]            m_motor_direction;
    logic [2:0]                   m_quadrant;

    motor_quadrant_detector_top u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_motor_position  (s_motor_position),
        .s_torque_command  (s_torque_command),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_motor_direction (m_motor_direction),
        .m_quadrant        (m_quadrant)
    );

    // Tracking state of the detector as the testbench sees it.
    logic signed [POS_WIDTH-1:0] track_pos   = '0;
    logic signed [1:0]           track_dir   = SIGN_ZERO;
    logic signed [1:0]           track_tsign = SIGN_POS;
    logic [HYST_WIDTH-1:0]       cfg_hyst    = HYST_RESET;
    logic [TOL_WIDTH-1:0]        cfg_tol     = TOL_RESET;

    motor_input_t     pending_inputs[$];
    operating_point_t predicted_points[$];
    motor_input_t     s_item;

    int  fail_count = 0;
    int  tx_gap = 0;
    int  rx_stall = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    bit  rx_hold_req = 1'b0;

    longint walk_pos = 0;
    int     walk_dir = 1;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [1:0] sign_code(longint v);
        if (v > 0) return SIGN_POS;
        if (v < 0) return SIGN_NEG;
        return SIGN_ZERO;
    endfunction

    // Updates the tracking state with one accepted transaction and queues the
    // direction and quadrant that the block has to report for it.
    task automatic track_motion(input motor_input_t mi);
        longint delta;
        longint mag;
        longint trq;
        logic signed [1:0] dsign;
        operating_point_t op;
        delta = longint'(mi.pos) - longint'(track_pos);
        if (delta > longint'(POS_HALF_SPAN))
            delta -= longint'(POS_SPAN);
        else if (delta < -longint'(POS_HALF_SPAN))
            delta += longint'(POS_SPAN);
        mag = (delta < 0) ? -delta : delta;
        dsign = sign_code(delta);
        if (track_dir == dsign) begin
            track_pos = mi.pos;
        end else if (mag >= longint'(cfg_hyst)) begin
            track_dir = dsign;
            track_pos = mi.pos;
        end
        trq = longint'(mi.trq);
        if (((trq < 0) ? -trq : trq) > longint'(cfg_tol))
            track_tsign = sign_code(trq);
        op.dir = track_dir;
        if (track_tsign == track_dir)
            op.quad = (track_tsign == SIGN_POS) ? QUADRANT_1 : QUADRANT_3;
        else
            op.quad = (track_tsign == SIGN_POS) ? QUADRANT_2 : QUADRANT_4;
        predicted_points.push_back(op);
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // Driver: a new item is offered only when the current one is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid)
                track_motion(s_item);
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (pending_inputs.size() > 0) begin
                s_item = pending_inputs.pop_front();
                s_valid <= 1'b1;
                s_motor_position <= s_item.pos;
                s_torque_command <= s_item.trq;
                if (tx_idle_on)
                    tx_gap = next_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transaction and drives m_ready.
    always @(posedge aclk) begin
        operating_point_t op;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_points.size() == 0) begin
                    note_failure($sformatf("%0t: unexpected result dir=%0d quad=%0d",
                                           $realtime, m_motor_direction, m_quadrant));
                end else begin
                    op = predicted_points.pop_front();
                    if (m_motor_direction !== op.dir)
                        note_failure($sformatf("%0t: direction expected %0d got %0d",
                                               $realtime, op.dir, m_motor_direction));
                    if (m_quadrant !== op.quad)
                        note_failure($sformatf("%0t: quadrant expected %0d got %0d",
                                               $realtime, op.quad, m_quadrant));
                end
            end
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_stall = LONG_HOLD_CYCLES;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 3) == 0)
                    rx_stall = next_gap();
            end
        end
    end

    task automatic write_reg(input logic [INDEX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_DIRECTION_HYSTERESIS)
            cfg_hyst = val[HYST_WIDTH-1:0];
        else if (idx == REG_TORQUE_TOLERANCE)
            cfg_tol = val[TOL_WIDTH-1:0];
    endtask

    task automatic add_input(input longint pos, input longint trq);
        motor_input_t mi;
        mi.pos = pos[POS_WIDTH-1:0];
        mi.trq = trq[TRQ_WIDTH-1:0];
        pending_inputs.push_back(mi);
    endtask

    // Waits until every queued item is accepted and every result has arrived.
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_inputs.size() != 0 || s_valid || predicted_points.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Mostly a steady walk of the motor with reversals around the
    // hysteresis, plus jumps near the rollover and fully random positions.
    task automatic queue_walk(input int count);
        int r;
        longint move;
        longint span;
        longint mag;
        longint tv;
        logic [63:0] raw;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            span = longint'(cfg_hyst >> 1) + 64;
            move = 0;
            if (r < 60) begin
                if (r < 5)
                    walk_dir = -walk_dir;
                move = longint'($urandom_range(0, int'(span))) * walk_dir;
            end else if (r < 75) begin
                walk_dir = -walk_dir;
                mag = longint'(cfg_hyst) + $urandom_range(0, 4) - 2;
                if (mag < 0)
                    mag = 0;
                move = mag * walk_dir;
            end else if (r < 85) begin
                move = 0;
            end else if (r < 93) begin
                walk_pos = longint'(POS_HALF_SPAN) - $urandom_range(0, 2000);
                if ($urandom_range(0, 1))
                    walk_pos = -walk_pos;
            end else begin
                raw = {$urandom, $urandom};
                walk_pos = longint'($signed(raw[POS_WIDTH-1:0]));
            end
            walk_pos += move;
            if (walk_pos > longint'(POS_HALF_SPAN))
                walk_pos -= longint'(POS_SPAN);
            else if (walk_pos < -longint'(POS_HALF_SPAN))
                walk_pos += longint'(POS_SPAN);

            r = $urandom_range(0, 99);
            if (r < 40) begin
                tv = longint'(cfg_tol) + $urandom_range(0, 4) - 2;
                if (tv < 0)
                    tv = 0;
                if ($urandom_range(0, 1))
                    tv = -tv;
                if (tv > 32767)
                    tv = 32767;
                if (tv < -32768)
                    tv = -32768;
            end else if (r < 80) begin
                raw = {32'd0, $urandom};
                tv = longint'($signed(raw[TRQ_WIDTH-1:0]));
            end else begin
                tv = $urandom_range(0, 20);
                if ($urandom_range(0, 1))
                    tv = -tv;
            end
            add_input(walk_pos, tv);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: small moves below the hysteresis, a flip each way,
        // both ends of the position range and of the 33-bit field.
        add_input(0, 0);
        add_input(100, 9);
        add_input(300, -9);
        add_input(301, 8);
        add_input(301, -8);
        add_input(200, 32767);
        add_input(0, -32768);
        add_input(64'sd3019898880, 9);
        add_input(-64'sd3019898880, -9);
        add_input(-64'sd3019898880, 32767);
        add_input(64'sd4294967295, 0);
        add_input(-64'sd4294967296, -32768);
        add_input(0, 32767);
        add_input(-256, -100);
        wait_drained();

        // Zero hysteresis and tolerance: a zero change clears the direction.
        write_reg(REG_DIRECTION_HYSTERESIS, 16'h0000);
        write_reg(REG_TORQUE_TOLERANCE, 16'h0000);
        write_reg(REG_SPARE_2, 16'hFFFF);
        write_reg(REG_SPARE_3, 16'hFFFF);
        add_input(500, 1);
        add_input(500, -1);
        add_input(499, 0);
        add_input(499, 1);
        walk_pos = 499;
        queue_walk(60);
        wait_drained();

        // Largest values: only the most negative torque passes the tolerance.
        write_reg(REG_DIRECTION_HYSTERESIS, 16'hFFFF);
        write_reg(REG_TORQUE_TOLERANCE, 16'hFFFF);
        add_input(65534, 32767);
        add_input(65535, -32768);
        add_input(-65535, 32767);
        add_input(-1, -32767);
        walk_pos = -1;
        queue_walk(60);
        wait_drained();

        // Moderate settings with no idling on either side.
        write_reg(REG_DIRECTION_HYSTERESIS, 16'($urandom_range(1, 1000)));
        write_reg(REG_TORQUE_TOLERANCE, 16'($urandom_range(0, 200)));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        queue_walk(100);
        wait_drained();

        // Receiver holds off while the sender keeps offering items.
        write_reg(REG_DIRECTION_HYSTERESIS, HYST_RESET);
        write_reg(REG_TORQUE_TOLERANCE, 16'(TOL_RESET));
        @(negedge aclk);
        rx_hold_req = 1'b1;
        queue_walk(80);
        wait_drained();

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        write_reg(REG_DIRECTION_HYSTERESIS, 16'($urandom_range(0, 65535)));
        write_reg(REG_TORQUE_TOLERANCE, 16'($urandom_range(0, 32767)));
        queue_walk(100);
        wait_drained();

        write_reg(REG_DIRECTION_HYSTERESIS, 16'($urandom_range(0, 300)));
        write_reg(REG_TORQUE_TOLERANCE, 16'($urandom_range(0, 50)));
        queue_walk(100);
        wait_drained();

        if (fail_count == 0 && predicted_points.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
sv/mqd_pkg.sv
sv/mqd_eval.sv
sv/motor_quadrant_detector_top.sv
verif/tb_motor_quadrant_detector_top.sv
